// File: rtl/ile_pkg.sv
`default_nettype none
package ile_pkg;

  localparam int unsigned ILE_CAPACITY = 64;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned POS_W        = 8;
  localparam int unsigned LEN_W        = 7;
  localparam logic [DATA_W-1:0] READ_NONE = {DATA_W{1'b1}};

  typedef enum logic [2:0] {
    KIND_GET      = 3'd0,
    KIND_INS_HEAD = 3'd1,
    KIND_INS_TAIL = 3'd2,
    KIND_INS_POS  = 3'd3,
    KIND_DEL_POS  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_GET  = 2'd1,
    OP_INS  = 2'd2,
    OP_DEL  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_READ  = 2'd1,
    S_WRITE = 2'd2
  } state_e;

  typedef struct packed {
    op_e     op;
    status_e status;
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/ile_mem.sv
`default_nettype none
module ile_mem import ile_pkg::*; #(
  parameter int unsigned CAPACITY = ILE_CAPACITY
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]                          wdata_i,
  input  wire logic                                       re_i,
  input  wire logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] raddr_i,
  output logic      [DATA_W-1:0]                          rdata_o
);

  logic [DATA_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/ile_seq.sv
`default_nettype none
module ile_seq import ile_pkg::*; #(
  parameter int unsigned CAPACITY = ILE_CAPACITY
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       accept_i,
  input  wire cmd_t                                       cmd_i,
  input  wire logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] tgt_i,
  input  wire logic [DATA_W-1:0]                          value_i,
  output logic                                            busy_o,
  output logic      [$clog2(CAPACITY + 1)-1:0]            count_o,
  output logic                                            result_valid_o,
  output logic      [DATA_W-1:0]                          read_value_o,
  output status_e                                         status_o,
  output logic                                            mem_we_o,
  output logic      [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] mem_waddr_o,
  output logic      [DATA_W-1:0]                          mem_wdata_o,
  output logic                                            mem_re_o,
  output logic      [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] mem_raddr_o,
  input  wire logic [DATA_W-1:0]                          mem_rdata_i
);

  localparam int unsigned AW    = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [AW-1:0]     bound_q, bound_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              rv_q, rv_d;
  logic [DATA_W-1:0] rd_q, rd_d;
  status_e           st_q, st_d;

  // shared index unit: one step toward the bound and one compare
  logic [AW-1:0]     step;
  logic              at_bound;

  assign step     = (op_q == OP_INS) ? idx_q - 1'b1 : idx_q + 1'b1;
  assign at_bound = (idx_q == bound_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
      op_q    <= OP_NONE;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
      op_q    <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    bound_q <= bound_d;
    val_q   <= val_d;
    rd_q    <= rd_d;
    st_q    <= st_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    bound_d     = bound_q;
    val_d       = val_q;
    cnt_d       = cnt_q;
    rv_d        = 1'b0;
    rd_d        = rd_q;
    st_d        = st_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = step;
    unique case (state_q)
      S_IDLE: begin
        if (accept_i) begin
          op_d  = cmd_i.op;
          val_d = value_i;
          unique case (cmd_i.op)
            OP_NONE: begin
              rv_d = 1'b1;
              rd_d = READ_NONE;
              st_d = cmd_i.status;
            end
            OP_GET: begin
              idx_d   = tgt_i;
              bound_d = tgt_i;
              state_d = S_READ;
            end
            OP_INS: begin
              idx_d   = cnt_q[AW-1:0];
              bound_d = tgt_i;
              state_d = S_READ;
            end
            OP_DEL: begin
              idx_d   = tgt_i;
              bound_d = AW'(cnt_q - 1'b1);
              state_d = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        unique case (op_q)
          OP_GET: begin
            mem_re_o    = 1'b1;
            mem_raddr_o = idx_q;
            state_d     = S_WRITE;
          end
          OP_INS: begin
            if (at_bound) begin
              // drop the new value into the opened slot
              mem_we_o    = 1'b1;
              mem_wdata_o = val_q;
              cnt_d       = cnt_q + 1'b1;
              rv_d        = 1'b1;
              rd_d        = READ_NONE;
              st_d        = ST_DONE;
              state_d     = S_IDLE;
            end else begin
              mem_re_o = 1'b1;
              state_d  = S_WRITE;
            end
          end
          OP_DEL: begin
            if (at_bound) begin
              cnt_d   = cnt_q - 1'b1;
              rv_d    = 1'b1;
              rd_d    = READ_NONE;
              st_d    = ST_DONE;
              state_d = S_IDLE;
            end else begin
              mem_re_o = 1'b1;
              state_d  = S_WRITE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_WRITE: begin
        if (op_q == OP_GET) begin
          rv_d    = 1'b1;
          rd_d    = mem_rdata_i;
          st_d    = ST_DONE;
          state_d = S_IDLE;
        end else begin
          // move the neighbor entry into the current slot and advance
          mem_we_o = 1'b1;
          idx_d    = step;
          state_d  = S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o         = (state_q != S_IDLE);
  assign count_o        = cnt_q;
  assign result_valid_o = rv_q;
  assign read_value_o   = rd_q;
  assign status_o       = st_q;

endmodule
`default_nettype wire

// File: rtl/indexed_list_engine_top.sv
// Indexed list engine: keeps an ordered list of up to CAPACITY signed 32-bit values
// in one single-port-read, single-port-write memory, packed from position 0. Issue
// an item (kind, position, value) with start_i while busy_o is low. A get reads
// one entry; an insert at position p moves every entry from p to the end of the
// list and a delete at p every entry after p, and every entry moved costs one
// memory read and one memory write through the same index unit. An item that is
// rejected (bad position, full list, unknown kind) is never busy. The result
// appears on the result ports for one cycle with result_valid_o, in the cycle
// after the operation finishes; it cannot be stalled, so capture it when it shows.
// length_o is the count after the operation. Memory contents are not reset.
`default_nettype none
module indexed_list_engine_top import ile_pkg::*; #(
  parameter int unsigned CAPACITY = ILE_CAPACITY
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [2:0]        kind_i,
  input  wire logic [POS_W-1:0]  position_i,
  input  wire logic [DATA_W-1:0] value_i,
  output logic                   result_valid_o,
  output logic [DATA_W-1:0]      read_value_o,
  output logic [1:0]             status_o,
  output logic [LEN_W-1:0]       length_o
);

  localparam int unsigned AW    = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CW    = CNT_W > POS_W ? CNT_W : POS_W;

  logic              accept;
  cmd_t              cmd;
  logic [AW-1:0]     tgt;
  logic [CNT_W-1:0]  count;
  logic [CW-1:0]     pos_ext;
  logic [CW-1:0]     cnt_ext;
  logic              neg;
  logic              full;
  status_e           status;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  assign accept  = start_i && !busy_o;
  assign neg     = position_i[POS_W-1];
  assign pos_ext = CW'(position_i[POS_W-2:0]);
  assign cnt_ext = CW'(count);
  assign full    = (count == CNT_W'(CAPACITY));

  // classify the item against the current count
  always_comb begin
    cmd.op     = OP_NONE;
    cmd.status = ST_RANGE;
    tgt        = pos_ext[AW-1:0];
    unique case (kind_i)
      KIND_GET, KIND_DEL_POS: begin
        if (!neg && (pos_ext < cnt_ext)) begin
          cmd.op     = (kind_i == KIND_GET) ? OP_GET : OP_DEL;
          cmd.status = ST_DONE;
        end
      end
      KIND_INS_HEAD: begin
        tgt = '0;
        if (full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.op     = OP_INS;
          cmd.status = ST_DONE;
        end
      end
      KIND_INS_TAIL: begin
        tgt = count[AW-1:0];
        if (full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.op     = OP_INS;
          cmd.status = ST_DONE;
        end
      end
      KIND_INS_POS: begin
        if (neg) begin
          tgt = '0;
        end
        if (!neg && (pos_ext > cnt_ext)) begin
          cmd.status = ST_RANGE;
        end else if (full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.op     = OP_INS;
          cmd.status = ST_DONE;
        end
      end
      default: ;
    endcase
  end

  ile_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .cmd_i         (cmd),
    .tgt_i         (tgt),
    .value_i       (value_i),
    .busy_o        (busy_o),
    .count_o       (count),
    .result_valid_o(result_valid_o),
    .read_value_o  (read_value_o),
    .status_o      (status),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  ile_mem #(
    .CAPACITY(CAPACITY)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign status_o = status;
  assign length_o = cnt_ext[LEN_W-1:0];

  a_fail_reads_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o != ST_DONE)) |-> (read_value_o == READ_NONE))
    else $error("rejected item returned a read value");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_ext <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_reject_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd.op == OP_NONE)) |=> (result_valid_o && !busy_o))
    else $error("rejected item did not complete in one cycle");

  a_full_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == ST_FULL)) |-> (count == CNT_W'(CAPACITY)))
    else $error("full status with list not full");

  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && $past(busy_o)) |-> !result_valid_o)
    else $error("result strobe while operation in progress");

endmodule
`default_nettype wire
